// File: hw/rtl/v3a_pkg.sv
// ----------------------------------------------------------------------------
// v3a_pkg
// shared widths, opcodes, status codes, payload structs and the saturate helper
// ----------------------------------------------------------------------------
`default_nettype none

package v3a_pkg;

  localparam int DW        = 32;
  localparam int OPW       = 4;
  localparam int FRAC_BITS = 16;
  localparam int MW        = DW + 1;          // multiplier operand
  localparam int PW        = 2 * MW;          // full product
  localparam int SW        = PW + 2;          // sum of products
  localparam int RNW       = SW - FRAC_BITS;  // rounded sum
  localparam int VW        = RNW + 1;         // rounded sum plus addend
  localparam int SQW       = 2 * DW;          // sum of squares
  localparam int QW        = FRAC_BITS + 1;   // normalize quotient
  localparam int DVW       = DW + FRAC_BITS + 1;

  typedef enum logic [OPW-1:0] {
    OP_ADD,
    OP_SUB,
    OP_SCALE,
    OP_DOT,
    OP_CROSS,
    OP_LERP,
    OP_LEN,
    OP_NORM,
    OP_NEG
  } op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  typedef logic signed [DW-1:0]  word_t;
  typedef logic signed [MW-1:0]  mop_t;
  typedef logic signed [PW-1:0]  prod_t;
  typedef logic signed [SW-1:0]  sum_t;
  typedef logic signed [RNW-1:0] rnd_t;
  typedef logic signed [VW-1:0]  vw_t;

  localparam word_t WMAX = {1'b0, {(DW-1){1'b1}}};
  localparam mop_t  ONE  = MW'(1) << FRAC_BITS;
  localparam sum_t  HALF = SW'(1) << (FRAC_BITS - 1);

  typedef struct packed {
    logic [OPW-1:0] op;
    word_t          ax;
    word_t          ay;
    word_t          az;
    word_t          bx;
    word_t          by;
    word_t          bz;
    word_t          scalar;
  } req_t;

  typedef struct packed {
    word_t      rx;
    word_t      ry;
    word_t      rz;
    word_t      rs;
    logic [1:0] status;
  } res_t;

  typedef struct packed {
    logic [OPW-1:0]       op;
    res_t                 res;
    logic [2:0]           sgn;
    logic [2:0][DW-1:0]   mag;
  } carry_t;

  // clip to the word range, msb of the result flags a clip
  function automatic logic [DW:0] sat_fn(input vw_t v);
    vw_t        hi;
    vw_t        lo;
    logic [DW:0] r;
    hi = vw_t'(WMAX);
    lo = ~hi;
    if (v > hi) begin
      r = {1'b1, WMAX};
    end else if (v < lo) begin
      r = {1'b1, ~WMAX};
    end else begin
      r = {1'b0, v[DW-1:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/v3a_req_if.sv
// ----------------------------------------------------------------------------
// v3a_req_if
// request channel: opcode, two vectors and a scalar with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface v3a_req_if;
  logic                          valid;
  logic                          ready;
  logic [v3a_pkg::OPW-1:0]       opcode;
  logic signed [v3a_pkg::DW-1:0] ax;
  logic signed [v3a_pkg::DW-1:0] ay;
  logic signed [v3a_pkg::DW-1:0] az;
  logic signed [v3a_pkg::DW-1:0] bx;
  logic signed [v3a_pkg::DW-1:0] by;
  logic signed [v3a_pkg::DW-1:0] bz;
  logic signed [v3a_pkg::DW-1:0] scalar;

  modport source (output valid, opcode, ax, ay, az, bx, by, bz, scalar, input ready);
  modport sink   (input valid, opcode, ax, ay, az, bx, by, bz, scalar, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/v3a_rsp_if.sv
// ----------------------------------------------------------------------------
// v3a_rsp_if
// result channel: vector, scalar and status with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface v3a_rsp_if;
  logic                          valid;
  logic                          ready;
  logic signed [v3a_pkg::DW-1:0] rx;
  logic signed [v3a_pkg::DW-1:0] ry;
  logic signed [v3a_pkg::DW-1:0] rz;
  logic signed [v3a_pkg::DW-1:0] rs;
  logic [1:0]                    status;

  modport source (output valid, rx, ry, rz, rs, status, input ready);
  modport sink   (input valid, rx, ry, rz, rs, status, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/v3a_front.sv
// ----------------------------------------------------------------------------
// v3a_front
// four stages: operand select, products, rounded sums, saturation
// ----------------------------------------------------------------------------
`default_nettype none

module v3a_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire logic                         in_valid,
  input  wire v3a_pkg::req_t                in_req,
  output logic                              out_valid,
  output v3a_pkg::carry_t                   out_carry,
  output logic [v3a_pkg::SQW-1:0]           out_sumsq
);

  localparam int DW = v3a_pkg::DW;
  localparam int FB = v3a_pkg::FRAC_BITS;
  localparam int SW = v3a_pkg::SW;

  // stage 1 operands
  v3a_pkg::mop_t ea [3];
  v3a_pkg::mop_t eb [3];
  v3a_pkg::mop_t es;
  v3a_pkg::mop_t et;
  v3a_pkg::mop_t ma [6];
  v3a_pkg::mop_t mb [6];
  v3a_pkg::mop_t lin [3];

  logic                     v1;
  logic [v3a_pkg::OPW-1:0]  op1;
  v3a_pkg::word_t           a1 [3];
  v3a_pkg::mop_t            ma1 [6];
  v3a_pkg::mop_t            mb1 [6];
  v3a_pkg::mop_t            lin1 [3];

  logic                     v2;
  logic [v3a_pkg::OPW-1:0]  op2;
  v3a_pkg::word_t           a2 [3];
  v3a_pkg::prod_t           p2 [6];
  v3a_pkg::mop_t            lin2 [3];

  v3a_pkg::sum_t            lane [3];
  v3a_pkg::sum_t            ltmp [3];
  v3a_pkg::sum_t            dsum;
  v3a_pkg::sum_t            dtmp;

  logic                     v3;
  logic [v3a_pkg::OPW-1:0]  op3;
  v3a_pkg::word_t           a3 [3];
  v3a_pkg::rnd_t            r3 [3];
  v3a_pkg::rnd_t            d3;
  logic [v3a_pkg::SQW-1:0]  sq3;
  v3a_pkg::mop_t            lin3 [3];

  v3a_pkg::vw_t             val [3];
  logic [DW:0]              sr [3];
  logic [DW:0]              sd;
  logic                     sat;
  v3a_pkg::carry_t          c4;

  always_comb begin
    ea[0] = v3a_pkg::mop_t'(in_req.ax);
    ea[1] = v3a_pkg::mop_t'(in_req.ay);
    ea[2] = v3a_pkg::mop_t'(in_req.az);
    eb[0] = v3a_pkg::mop_t'(in_req.bx);
    eb[1] = v3a_pkg::mop_t'(in_req.by);
    eb[2] = v3a_pkg::mop_t'(in_req.bz);
    es    = v3a_pkg::mop_t'(in_req.scalar);
    // weight clamped to 0..1
    if (es < 0) begin
      et = '0;
    end else if (es > v3a_pkg::ONE) begin
      et = v3a_pkg::ONE;
    end else begin
      et = es;
    end
    for (int i = 0; i < 6; i++) begin
      ma[i] = '0;
      mb[i] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      lin[i] = '0;
    end
    case (in_req.op)
      v3a_pkg::OP_ADD: begin
        for (int i = 0; i < 3; i++) lin[i] = ea[i] + eb[i];
      end
      v3a_pkg::OP_SUB: begin
        for (int i = 0; i < 3; i++) lin[i] = ea[i] - eb[i];
      end
      v3a_pkg::OP_NEG: begin
        for (int i = 0; i < 3; i++) lin[i] = -ea[i];
      end
      v3a_pkg::OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          ma[i] = ea[i];
          mb[i] = es;
        end
      end
      v3a_pkg::OP_DOT: begin
        for (int i = 0; i < 3; i++) begin
          ma[i] = ea[i];
          mb[i] = eb[i];
        end
      end
      v3a_pkg::OP_CROSS: begin
        // lane i gets the positive term, lane i+3 the subtracted one
        ma[0] = ea[1]; mb[0] = eb[2];
        ma[3] = ea[2]; mb[3] = eb[1];
        ma[1] = ea[2]; mb[1] = eb[0];
        ma[4] = ea[0]; mb[4] = eb[2];
        ma[2] = ea[0]; mb[2] = eb[1];
        ma[5] = ea[1]; mb[5] = eb[0];
      end
      v3a_pkg::OP_LERP: begin
        for (int i = 0; i < 3; i++) begin
          ma[i] = eb[i] - ea[i];
          mb[i] = et;
        end
      end
      v3a_pkg::OP_LEN, v3a_pkg::OP_NORM: begin
        for (int i = 0; i < 3; i++) begin
          ma[i] = ea[i];
          mb[i] = ea[i];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1   <= in_req.op;
      a1[0] <= in_req.ax;
      a1[1] <= in_req.ay;
      a1[2] <= in_req.az;
      for (int i = 0; i < 6; i++) begin
        ma1[i] <= ma[i];
        mb1[i] <= mb[i];
      end
      for (int i = 0; i < 3; i++) lin1[i] <= lin[i];

      op2 <= op1;
      for (int i = 0; i < 6; i++) p2[i] <= ma1[i] * mb1[i];
      for (int i = 0; i < 3; i++) begin
        a2[i]   <= a1[i];
        lin2[i] <= lin1[i];
      end

      op3 <= op2;
      for (int i = 0; i < 3; i++) begin
        a3[i]   <= a2[i];
        lin3[i] <= lin2[i];
        r3[i]   <= ltmp[i][SW-1:FB];
      end
      d3  <= dtmp[SW-1:FB];
      sq3 <= dsum[v3a_pkg::SQW-1:0];

      out_carry <= c4;
      out_sumsq <= sq3;
    end
  end

  // stage 3: lane sums rounded half up
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (op2 == v3a_pkg::OP_CROSS) begin
        lane[i] = v3a_pkg::sum_t'(p2[i]) - v3a_pkg::sum_t'(p2[i+3]);
      end else begin
        lane[i] = v3a_pkg::sum_t'(p2[i]);
      end
      ltmp[i] = lane[i] + v3a_pkg::HALF;
    end
    dsum = v3a_pkg::sum_t'(p2[0]) + v3a_pkg::sum_t'(p2[1]) + v3a_pkg::sum_t'(p2[2]);
    dtmp = dsum + v3a_pkg::HALF;
  end

  // stage 4: select and saturate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (op3)
        v3a_pkg::OP_ADD, v3a_pkg::OP_SUB, v3a_pkg::OP_NEG:
          val[i] = v3a_pkg::vw_t'(lin3[i]);
        v3a_pkg::OP_SCALE, v3a_pkg::OP_CROSS:
          val[i] = v3a_pkg::vw_t'(r3[i]);
        v3a_pkg::OP_LERP:
          val[i] = v3a_pkg::vw_t'(a3[i]) + v3a_pkg::vw_t'(r3[i]);
        default:
          val[i] = '0;
      endcase
      sr[i] = v3a_pkg::sat_fn(val[i]);
    end
    sd  = v3a_pkg::sat_fn(v3a_pkg::vw_t'(d3));
    sat = sr[0][DW] | sr[1][DW] | sr[2][DW] | ((op3 == v3a_pkg::OP_DOT) & sd[DW]);
    c4.op         = op3;
    c4.res.rx     = sr[0][DW-1:0];
    c4.res.ry     = sr[1][DW-1:0];
    c4.res.rz     = sr[2][DW-1:0];
    c4.res.rs     = (op3 == v3a_pkg::OP_DOT) ? sd[DW-1:0] : '0;
    c4.res.status = sat ? v3a_pkg::ST_SAT : v3a_pkg::ST_OK;
    for (int i = 0; i < 3; i++) begin
      c4.sgn[i] = a3[i][DW-1];
      c4.mag[i] = a3[i][DW-1] ? (~a3[i] + 1'b1) : a3[i];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/v3a_sqrt.sv
// ----------------------------------------------------------------------------
// v3a_sqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module v3a_sqrt (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire logic                    in_valid,
  input  wire v3a_pkg::carry_t         in_carry,
  input  wire logic [v3a_pkg::SQW-1:0] in_sumsq,
  output logic                         out_valid,
  output v3a_pkg::carry_t              out_carry,
  output logic [v3a_pkg::DW-1:0]       out_len
);

  localparam int NS  = v3a_pkg::DW;
  localparam int SQW = v3a_pkg::SQW;
  localparam int TW  = SQW + 2;

  logic            v    [NS+1];
  v3a_pkg::carry_t c    [NS+1];
  logic [SQW-1:0]  rem  [NS+1];
  logic [NS-1:0]   root [NS+1];

  assign v[0]    = in_valid;
  assign c[0]    = in_carry;
  assign rem[0]  = in_sumsq;
  assign root[0] = '0;

  for (genvar g = 0; g < NS; g++) begin : g_stage
    localparam int K = NS - 1 - g;
    localparam logic [NS-1:0] BITK = NS'(1) << K;
    logic [TW-1:0] trial;

    // (r + 2^k)^2 - r^2
    assign trial = (TW'(root[g]) << (K + 1)) + (TW'(1) << (2 * K));

    always_ff @(posedge clk) begin
      if (rst) begin
        v[g+1] <= 1'b0;
      end else if (en) begin
        v[g+1] <= v[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        c[g+1] <= c[g];
        if (TW'(rem[g]) >= trial) begin
          rem[g+1]  <= rem[g] - trial[SQW-1:0];
          root[g+1] <= root[g] | BITK;
        end else begin
          rem[g+1]  <= rem[g];
          root[g+1] <= root[g];
        end
      end
    end
  end

  assign out_valid = v[NS];
  assign out_carry = c[NS];
  assign out_len   = root[NS];

endmodule

`default_nettype wire

// File: hw/rtl/v3a_div.sv
// ----------------------------------------------------------------------------
// v3a_div
// three-lane restoring divider for normalize, then the final result select
// ----------------------------------------------------------------------------
`default_nettype none

module v3a_div (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  wire v3a_pkg::carry_t       in_carry,
  input  wire logic [v3a_pkg::DW-1:0] in_len,
  output logic                       out_valid,
  output v3a_pkg::res_t              out_res
);

  localparam int DW  = v3a_pkg::DW;
  localparam int NQ  = v3a_pkg::QW;
  localparam int DVW = v3a_pkg::DVW;

  logic            v   [NQ+1];
  v3a_pkg::carry_t c   [NQ+1];
  logic [DW-1:0]   len [NQ+1];
  logic [DVW-1:0]  rem [NQ+1][3];
  logic [NQ-1:0]   q   [NQ+1][3];

  v3a_pkg::res_t   fin;

  assign v[0]   = in_valid;
  assign c[0]   = in_carry;
  assign len[0] = in_len;

  for (genvar i = 0; i < 3; i++) begin : g_init
    assign rem[0][i] = DVW'(in_carry.mag[i]) << v3a_pkg::FRAC_BITS;
    assign q[0][i]   = '0;
  end

  for (genvar g = 0; g < NQ; g++) begin : g_stage
    localparam int J = NQ - 1 - g;
    localparam logic [NQ-1:0] BITJ = NQ'(1) << J;
    logic [DVW-1:0] dv;

    assign dv = DVW'(len[g]) << J;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[g+1] <= 1'b0;
      end else if (en) begin
        v[g+1] <= v[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        c[g+1]   <= c[g];
        len[g+1] <= len[g];
        for (int i = 0; i < 3; i++) begin
          if (rem[g][i] >= dv) begin
            rem[g+1][i] <= rem[g][i] - dv;
            q[g+1][i]   <= q[g][i] | BITJ;
          end else begin
            rem[g+1][i] <= rem[g][i];
            q[g+1][i]   <= q[g][i];
          end
        end
      end
    end
  end

  always_comb begin
    fin = c[NQ].res;
    case (c[NQ].op)
      v3a_pkg::OP_LEN: begin
        if (len[NQ][DW-1]) begin
          fin.rs     = v3a_pkg::WMAX;
          fin.status = v3a_pkg::ST_SAT;
        end else begin
          fin.rs = len[NQ];
        end
      end
      v3a_pkg::OP_NORM: begin
        if (len[NQ] == '0) begin
          fin.status = v3a_pkg::ST_ZERO;
        end else begin
          fin.rx = c[NQ].sgn[0] ? -DW'(q[NQ][0]) : DW'(q[NQ][0]);
          fin.ry = c[NQ].sgn[1] ? -DW'(q[NQ][1]) : DW'(q[NQ][1]);
          fin.rz = c[NQ].sgn[2] ? -DW'(q[NQ][2]) : DW'(q[NQ][2]);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v[NQ];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res <= fin;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/vector3_fixed_point_alu_unit.sv
// ----------------------------------------------------------------------------
// vector3_fixed_point_alu_unit
// Q16.16 three-component vector alu: add, sub, scale, dot, cross, lerp,
// length, normalize and negate with saturation and status
// ----------------------------------------------------------------------------
// every opcode takes the same path from request accept to result valid
// throughput: one request per cycle unless stalled; the 32-stage square root and the
//   17-stage normalize divider are fully pipelined
// the whole pipeline stalls only when the output register and its skid
//   register are both full; ready is the registered skid-empty flag
// reset: synchronous, clears all valid bits and the output/skid flags
`default_nettype none

module vector3_fixed_point_alu_unit (
  input  wire logic clk,
  input  wire logic rst,
  v3a_req_if.sink   req,
  v3a_rsp_if.source rsp
);

  logic                 en;
  v3a_pkg::req_t        in_req;

  // front to square root
  logic                 f_valid;
  v3a_pkg::carry_t      f_carry;
  logic [v3a_pkg::SQW-1:0] f_sumsq;

  // square root to divider
  logic                 s_valid;
  v3a_pkg::carry_t      s_carry;
  logic [v3a_pkg::DW-1:0] s_len;

  // divider to output
  logic                 d_valid;
  v3a_pkg::res_t        d_res;

  // output register plus one skid entry
  logic                 out_v;
  v3a_pkg::res_t        out_r;
  logic                 skid_v;
  v3a_pkg::res_t        skid_r;

  // pipeline moves whenever the skid entry is free
  assign en        = ~skid_v;
  assign req.ready = en;

  assign in_req.op     = req.opcode;
  assign in_req.ax     = req.ax;
  assign in_req.ay     = req.ay;
  assign in_req.az     = req.az;
  assign in_req.bx     = req.bx;
  assign in_req.by     = req.by;
  assign in_req.bz     = req.bz;
  assign in_req.scalar = req.scalar;

  // operand select, products, rounded sums, saturation
  v3a_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (req.valid),
    .in_req    (in_req),
    .out_valid (f_valid),
    .out_carry (f_carry),
    .out_sumsq (f_sumsq)
  );

  // floor square root of the sum of squares
  v3a_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .in_carry  (f_carry),
    .in_sumsq  (f_sumsq),
    .out_valid (s_valid),
    .out_carry (s_carry),
    .out_len   (s_len)
  );

  // normalize quotients and final merge of length/normalize results
  v3a_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_valid),
    .in_carry  (s_carry),
    .in_len    (s_len),
    .out_valid (d_valid),
    .out_res   (d_res)
  );

  // output register with skid: a finished result waiting downstream
  // does not block the next request
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (out_v && rsp.ready) begin
      if (skid_v) begin
        skid_v <= 1'b0;
      end else begin
        out_v <= en & d_valid;
      end
    end else if (!out_v) begin
      out_v <= en & d_valid;
    end else if (en && d_valid) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_v && rsp.ready) begin
      if (skid_v) begin
        out_r <= skid_r;
      end else begin
        out_r <= d_res;
      end
    end else if (!out_v) begin
      out_r <= d_res;
    end else if (en && d_valid) begin
      skid_r <= d_res;
    end
  end

  assign rsp.valid  = out_v;
  assign rsp.rx     = out_r.rx;
  assign rsp.ry     = out_r.ry;
  assign rsp.rz     = out_r.rz;
  assign rsp.rs     = out_r.rs;
  assign rsp.status = out_r.status;

endmodule

`default_nettype wire

// File: hw/rtl/v3a_chk.sv
// ----------------------------------------------------------------------------
// v3a_chk
// port-level checks on the result channel, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module v3a_chk (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   rsp_valid,
  input wire logic                   rsp_ready,
  input wire logic [v3a_pkg::DW-1:0] rx,
  input wire logic [v3a_pkg::DW-1:0] ry,
  input wire logic [v3a_pkg::DW-1:0] rz,
  input wire logic [v3a_pkg::DW-1:0] rs,
  input wire logic [1:0]             status
);

  // a stalled result keeps valid, rx, rs and status
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rx) && $stable(rs) && $stable(status))
    else $error("result changed while stalled");

  // nothing comes out right after reset
  a_rst: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  a_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> status == v3a_pkg::ST_OK || status == v3a_pkg::ST_SAT ||
                  status == v3a_pkg::ST_ZERO)
    else $error("undefined status");

  // zero-length normalize clears every output
  a_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == v3a_pkg::ST_ZERO |-> rx == '0 && ry == '0 && rz == '0 && rs == '0)
    else $error("zero-length result not cleared");

  // scalar results never come with a vector
  a_scalar: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rs != '0 |-> rx == '0 && ry == '0 && rz == '0)
    else $error("scalar and vector result together");

endmodule

bind vector3_fixed_point_alu_unit v3a_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rx        (rsp.rx),
  .ry        (rsp.ry),
  .rz        (rsp.rz),
  .rs        (rsp.rs),
  .status    (rsp.status)
);

`default_nettype wire

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// testbench for the Q16.16 vector alu: a queue-fed driver sends requests, a
// monitor compares every result against a behavioral predictor, with phases
// of random idling on both sides and one long output hold-off
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import v3a_pkg::*;

  localparam int  LATENCY     = 55;
  localparam int  N_RANDOM    = 1130;
  localparam int  CYCLE_LIMIT = 400000;
  localparam int  ONE_Q       = 1 << FRAC_BITS;
  localparam longint W_MAX    = 64'sd2147483647;
  localparam longint W_MIN    = -64'sd2147483648;

  logic clk;
  logic rst;

  v3a_req_if req ();
  v3a_rsp_if rsp ();

  vector3_fixed_point_alu_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // pending requests and the results they should produce
  req_t   pending_reqs[$];
  res_t   expected_results[$];

  // idle pressure in percent, changed per phase by the stimulus block
  int     send_idle_pct;
  int     recv_stall_pct;
  int     hold_off_cycles;

  int     mismatches;
  int     results_seen;
  int     reqs_sent;
  longint cycle_count;
  int     op_counts[16];
  int     sat_count;
  int     zero_len_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // floor shift on a signed 128-bit value
  function automatic logic signed [127:0] shr_floor(input logic signed [127:0] v);
    return v >>> FRAC_BITS;
  endfunction

  // round half up, add the addend, then clip to a word and note a clip
  function automatic word_t round_clip(input logic signed [127:0] prod_sum,
                                       input logic signed [127:0] addend,
                                       inout logic clipped);
    logic signed [127:0] v;
    v = shr_floor(prod_sum + (128'sd1 <<< (FRAC_BITS - 1))) + addend;
    return clip_word(v, clipped);
  endfunction

  function automatic word_t clip_word(input logic signed [127:0] v,
                                      inout logic clipped);
    if (v > W_MAX) begin
      clipped = 1'b1;
      return word_t'(W_MAX);
    end
    if (v < W_MIN) begin
      clipped = 1'b1;
      return word_t'(W_MIN);
    end
    return word_t'(v);
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] root;
    logic [63:0] bit_q;
    root  = 0;
    bit_q = 64'd1 << 62;
    while (bit_q > n) bit_q = bit_q >> 2;
    while (bit_q != 0) begin
      if (n >= root + bit_q) begin
        n    = n - (root + bit_q);
        root = (root >> 1) + bit_q;
      end else begin
        root = root >> 1;
      end
      bit_q = bit_q >> 2;
    end
    return root;
  endfunction

  function automatic res_t alu_result(input req_t r);
    res_t                res;
    logic signed [127:0] a[3];
    logic signed [127:0] b[3];
    logic signed [127:0] s;
    logic signed [127:0] t;
    logic signed [127:0] acc;
    logic [63:0]         sumsq;
    logic [63:0]         len;
    logic [63:0]         m;
    logic [63:0]         q;
    word_t               v[3];
    logic                clipped;
    a[0] = r.ax; a[1] = r.ay; a[2] = r.az;
    b[0] = r.bx; b[1] = r.by; b[2] = r.bz;
    s = r.scalar;
    v = '{default: '0};
    res = '0;
    clipped = 1'b0;
    case (r.op)
      OP_ADD:   for (int i = 0; i < 3; i++) v[i] = clip_word(a[i] + b[i], clipped);
      OP_SUB:   for (int i = 0; i < 3; i++) v[i] = clip_word(a[i] - b[i], clipped);
      OP_NEG:   for (int i = 0; i < 3; i++) v[i] = clip_word(-a[i], clipped);
      OP_SCALE: for (int i = 0; i < 3; i++) v[i] = round_clip(a[i] * s, 0, clipped);
      OP_DOT: begin
        acc = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        res.rs = round_clip(acc, 0, clipped);
      end
      OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          acc  = a[(i+1)%3] * b[(i+2)%3] - a[(i+2)%3] * b[(i+1)%3];
          v[i] = round_clip(acc, 0, clipped);
        end
      end
      OP_LERP: begin
        // weight clamped to 0..1
        t = (s < 0) ? 0 : ((s > ONE_Q) ? ONE_Q : s);
        for (int i = 0; i < 3; i++) v[i] = round_clip((b[i] - a[i]) * t, a[i], clipped);
      end
      OP_LEN, OP_NORM: begin
        sumsq = 0;
        for (int i = 0; i < 3; i++) begin
          m     = (a[i] < 0) ? 64'(-a[i]) : 64'(a[i]);
          sumsq = sumsq + m * m;
        end
        len = floor_sqrt(sumsq);
        if (r.op == OP_LEN) begin
          if (len > 64'(W_MAX)) begin
            clipped = 1'b1;
            res.rs  = word_t'(W_MAX);
          end else begin
            res.rs = word_t'(len);
          end
        end else if (len == 0) begin
          res.status = ST_ZERO;
        end else begin
          for (int i = 0; i < 3; i++) begin
            m    = (a[i] < 0) ? 64'(-a[i]) : 64'(a[i]);
            q    = (m << FRAC_BITS) / len;
            v[i] = (a[i] < 0) ? -word_t'(q) : word_t'(q);
          end
        end
      end
      default: ;
    endcase
    res.rx = v[0];
    res.ry = v[1];
    res.rz = v[2];
    if (clipped && res.status == ST_OK) res.status = ST_SAT;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: takes the head of the queue when it may offer, records a prediction on acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      logic take_next;
      take_next = !req.valid || req.ready;
      if (req.valid && req.ready) begin
        // accepted this edge: predict and record
        expected_results.push_back(alu_result({req.opcode, req.ax, req.ay, req.az,
                                               req.bx, req.by, req.bz, req.scalar}));
        op_counts[req.opcode]++;
        reqs_sent++;
      end
      if (take_next) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          req_t nxt;
          nxt = pending_reqs.pop_front();
          req.valid  <= 1'b1;
          req.opcode <= nxt.op;
          req.ax     <= nxt.ax;
          req.ay     <= nxt.ay;
          req.az     <= nxt.az;
          req.bx     <= nxt.bx;
          req.by     <= nxt.by;
          req.bz     <= nxt.bz;
          req.scalar <= nxt.scalar;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver ready: random stalls, plus a long hold-off when requested
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      rsp.ready       <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: compare each result with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      res_t got;
      res_t want;
      got = {rsp.rx, rsp.ry, rsp.rz, rsp.rs, rsp.status};
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("error: unexpected result %h", got);
      end else begin
        want = expected_results.pop_front();
        if (got.status == ST_SAT) sat_count++;
        if (got.status == ST_ZERO) zero_len_count++;
        if (got.rx !== want.rx || got.ry !== want.ry || got.rz !== want.rz ||
            got.rs !== want.rs || got.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("error: result %0d exp rx=%h ry=%h rz=%h rs=%h st=%0d got rx=%h ry=%h rz=%h rs=%h st=%0d",
                     results_seen, want.rx, want.ry, want.rz, want.rs, want.status,
                     got.rx, got.ry, got.rz, got.rs, got.status);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // operand with a bias toward edge values and small magnitudes
  function automatic word_t rand_word();
    case ($urandom_range(9))
      0: return word_t'(W_MAX);
      1: return word_t'(W_MIN);
      2: return word_t'(0);
      3: return word_t'($urandom_range(2 * ONE_Q)) - word_t'(ONE_Q);
      4: return word_t'($urandom_range(ONE_Q));
      5: return -word_t'($urandom_range(255));
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic req_t rand_req();
    req_t r;
    r.op = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
    r.ax = rand_word(); r.ay = rand_word(); r.az = rand_word();
    r.bx = rand_word(); r.by = rand_word(); r.bz = rand_word();
    r.scalar = ($urandom_range(3) == 0) ? word_t'($urandom_range(ONE_Q + 2)) - 1
                                        : rand_word();
    // some zero vectors for the normalize special case
    if (r.op == OP_NORM && $urandom_range(7) == 0) {r.ax, r.ay, r.az} = '0;
    return r;
  endfunction

  task automatic add_req(input logic [3:0] op, input word_t ax, ay, az, bx, by, bz, sc);
    pending_reqs.push_back({op, ax, ay, az, bx, by, bz, sc});
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || req.valid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    word_t mx;
    word_t mn;
    mx = word_t'(W_MAX);
    mn = word_t'(W_MIN);
    rst             = 1'b1;
    req.valid       = 1'b0;
    req.opcode      = '0;
    {req.ax, req.ay, req.az, req.bx, req.by, req.bz, req.scalar} = '0;
    rsp.ready       = 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_off_cycles = 0;
    mismatches      = 0;
    results_seen    = 0;
    reqs_sent       = 0;
    cycle_count     = 0;
    sat_count       = 0;
    zero_len_count  = 0;
    foreach (op_counts[i]) op_counts[i] = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, every opcode, saturation, clamp and zero-length cases
    add_req(OP_ADD,   mx, mn, 1, mx, mn, -1, 0);
    add_req(OP_SUB,   mn, mx, 0, mx, mn, 5, 0);
    add_req(OP_NEG,   mn, mx, 0, 0, 0, 0, 0);
    add_req(OP_SCALE, mx, mn, ONE_Q, 0, 0, 0, mx);
    add_req(OP_SCALE, 3, -3, 1, 0, 0, 0, ONE_Q / 2);
    add_req(OP_DOT,   mx, mx, mx, mx, mx, mx, 0);
    add_req(OP_DOT,   ONE_Q, 2 * ONE_Q, -ONE_Q, ONE_Q, ONE_Q, ONE_Q, 0);
    add_req(OP_CROSS, ONE_Q, 0, 0, 0, ONE_Q, 0, 0);
    add_req(OP_CROSS, mn, mx, mn, mx, mn, mx, 0);
    add_req(OP_LERP,  0, ONE_Q, mn, ONE_Q, 0, mx, -5);
    add_req(OP_LERP,  0, ONE_Q, mn, ONE_Q, 0, mx, ONE_Q + 7);
    add_req(OP_LERP,  mn, 10, 0, mx, -10, 3, ONE_Q / 2);
    add_req(OP_LERP,  mn, mx, 0, mx, mn, 3, mn);
    add_req(OP_LEN,   mn, mn, mn, 0, 0, 0, 0);
    add_req(OP_LEN,   3 * ONE_Q, 4 * ONE_Q, 0, 0, 0, 0, 0);
    add_req(OP_LEN,   0, 0, 0, 0, 0, 0, 0);
    add_req(OP_NORM,  0, 0, 0, 1, 1, 1, 1);
    add_req(OP_NORM,  mn, mx, 1, 0, 0, 0, 0);
    add_req(OP_NORM,  0, -ONE_Q, 0, 0, 0, 0, 0);
    add_req(4'd9,     mx, mx, mx, mx, mx, mx, mx);
    add_req(4'd15,    -1, -1, -1, -1, -1, -1, -1);
    drain();

    // random phases: free running, sender idle, receiver stalls, both
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 62 : (phase == 3) ? 18 : 0;
      recv_stall_pct = (phase == 2) ? 62 : (phase == 3) ? 18 : 0;
      for (int n = 0; n < N_RANDOM / 4; n++) pending_reqs.push_back(rand_req());
      if (phase == 0) begin
        // long output hold-off while requests keep coming, fills the pipeline
        repeat (5) @(posedge clk);
        hold_off_cycles <= 300;
      end
      drain();
    end

    repeat (LATENCY + 10) @(posedge clk);
    $display("sent %0d requests, checked %0d results (%0d saturated, %0d zero-length)",
             reqs_sent, results_seen, sat_count, zero_len_count);
    $display("opcodes add..neg: %0d %0d %0d %0d %0d %0d %0d %0d %0d, unused %0d",
             op_counts[0], op_counts[1], op_counts[2], op_counts[3], op_counts[4],
             op_counts[5], op_counts[6], op_counts[7], op_counts[8],
             reqs_sent - op_counts[0] - op_counts[1] - op_counts[2] - op_counts[3]
             - op_counts[4] - op_counts[5] - op_counts[6] - op_counts[7] - op_counts[8]);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("mismatches %0d, results left %0d", mismatches, expected_results.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
